FILE: rtl/im2col_agu_pkg.sv
package im2col_agu_pkg;

   // Defaults for the top-level parameters
   localparam int MAX_SIDE_DEF           = 4096;
   localparam int MAX_CHANNEL_BLOCKS_DEF = 512;

   // Vector geometry: one move carries LANES elements
   localparam int LANES      = 8;
   localparam int LANES_LOG2 = $clog2(LANES);

   // Field widths
   localparam int SIZE_REG_W    = 13;
   localparam int CB_REG_W      = 10;
   localparam int GEOM_W        = 32;
   localparam int NIBBLE_W      = 4;
   localparam int MOVE_W        = 41;
   localparam int SRC_OFFSET_W  = 36;
   localparam int DEST_OFFSET_W = 44;

   // Register port
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 3;

   localparam logic [SIZE_REG_W-1:0] SIZE_RESET = SIZE_REG_W'(1);
   localparam logic [CB_REG_W-1:0]   CB_RESET   = CB_REG_W'(1);
   localparam logic [GEOM_W-1:0]     GEOM_RESET = 32'h0011_1111;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SRC_HEIGHT      = 3'd0,
      REG_SRC_WIDTH       = 3'd1,
      REG_OUT_HEIGHT      = 3'd2,
      REG_OUT_WIDTH       = 3'd3,
      REG_CHANNEL_BLOCKS  = 3'd4,
      REG_WINDOW_GEOMETRY = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [SIZE_REG_W-1:0] src_height;
      logic [SIZE_REG_W-1:0] src_width;
      logic [SIZE_REG_W-1:0] out_height;
      logic [SIZE_REG_W-1:0] out_width;
      logic [CB_REG_W-1:0]   channel_blocks;
      logic [GEOM_W-1:0]     window_geometry;
   } cfg_type;

   // Kernel, stride and dilation fields of zero count as one
   function automatic logic [NIBBLE_W-1:0] nz4(input logic [NIBBLE_W-1:0] v);
      logic [NIBBLE_W-1:0] r;
      r = (v == '0) ? NIBBLE_W'(1) : v;
      return r;
   endfunction

endpackage

FILE: rtl/im2col_agu_if.sv
interface im2col_agu_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface im2col_agu_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic [im2col_agu_pkg::SRC_OFFSET_W-1:0]   source_offset;
   logic [im2col_agu_pkg::DEST_OFFSET_W-1:0]  dest_offset;
   logic                                      zero_fill;
   logic                                      last_move;

   modport source (output valid, output source_offset, output dest_offset,
                   output zero_fill, output last_move, input ready);
   modport sink   (input valid, input source_offset, input dest_offset,
                   input zero_fill, input last_move, output ready);
endinterface

FILE: rtl/im2col_agu_csr.sv
module im2col_agu_csr (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [im2col_agu_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [im2col_agu_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [im2col_agu_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                   pready,
   output im2col_agu_pkg::cfg_type                cfg
);

   im2col_agu_pkg::cfg_type       cfg_ff;
   im2col_agu_pkg::reg_index_type reg_idx;
   logic                          wr_en;

   assign reg_idx = im2col_agu_pkg::reg_index_type'(
                       paddr[im2col_agu_pkg::CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_height      <= im2col_agu_pkg::SIZE_RESET;
         cfg_ff.src_width       <= im2col_agu_pkg::SIZE_RESET;
         cfg_ff.out_height      <= im2col_agu_pkg::SIZE_RESET;
         cfg_ff.out_width       <= im2col_agu_pkg::SIZE_RESET;
         cfg_ff.channel_blocks  <= im2col_agu_pkg::CB_RESET;
         cfg_ff.window_geometry <= im2col_agu_pkg::GEOM_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            im2col_agu_pkg::REG_SRC_HEIGHT: begin
               cfg_ff.src_height <= pwdata[im2col_agu_pkg::SIZE_REG_W-1:0];
            end
            im2col_agu_pkg::REG_SRC_WIDTH: begin
               cfg_ff.src_width <= pwdata[im2col_agu_pkg::SIZE_REG_W-1:0];
            end
            im2col_agu_pkg::REG_OUT_HEIGHT: begin
               cfg_ff.out_height <= pwdata[im2col_agu_pkg::SIZE_REG_W-1:0];
            end
            im2col_agu_pkg::REG_OUT_WIDTH: begin
               cfg_ff.out_width <= pwdata[im2col_agu_pkg::SIZE_REG_W-1:0];
            end
            im2col_agu_pkg::REG_CHANNEL_BLOCKS: begin
               cfg_ff.channel_blocks <= pwdata[im2col_agu_pkg::CB_REG_W-1:0];
            end
            im2col_agu_pkg::REG_WINDOW_GEOMETRY: begin
               cfg_ff.window_geometry <= pwdata[im2col_agu_pkg::GEOM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      case (reg_idx)
         im2col_agu_pkg::REG_SRC_HEIGHT: begin
            prdata = im2col_agu_pkg::CSR_DATA_W'(cfg_ff.src_height);
         end
         im2col_agu_pkg::REG_SRC_WIDTH: begin
            prdata = im2col_agu_pkg::CSR_DATA_W'(cfg_ff.src_width);
         end
         im2col_agu_pkg::REG_OUT_HEIGHT: begin
            prdata = im2col_agu_pkg::CSR_DATA_W'(cfg_ff.out_height);
         end
         im2col_agu_pkg::REG_OUT_WIDTH: begin
            prdata = im2col_agu_pkg::CSR_DATA_W'(cfg_ff.out_width);
         end
         im2col_agu_pkg::REG_CHANNEL_BLOCKS: begin
            prdata = im2col_agu_pkg::CSR_DATA_W'(cfg_ff.channel_blocks);
         end
         im2col_agu_pkg::REG_WINDOW_GEOMETRY: begin
            prdata = im2col_agu_pkg::CSR_DATA_W'(cfg_ff.window_geometry);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

endmodule

FILE: rtl/im2col_agu_core.sv
module im2col_agu_core #(
   parameter int MAX_SIDE           = im2col_agu_pkg::MAX_SIDE_DEF,
   parameter int MAX_CHANNEL_BLOCKS = im2col_agu_pkg::MAX_CHANNEL_BLOCKS_DEF
) (
   input  logic                                      clock,
   input  logic                                      reset,
   input  im2col_agu_pkg::cfg_type                   cfg,
   input  logic                                      in_valid,
   output logic                                      in_ready,
   input  logic                                      in_restart,
   output logic                                      out_valid,
   input  logic                                      out_ready,
   output logic [im2col_agu_pkg::SRC_OFFSET_W-1:0]   out_source_offset,
   output logic [im2col_agu_pkg::DEST_OFFSET_W-1:0]  out_dest_offset,
   output logic                                      out_zero_fill,
   output logic                                      out_last_move
);

   localparam int SIDE_W = $clog2(MAX_SIDE);
   localparam int LIM_W  = SIDE_W + 1;
   localparam int CB_W   = (MAX_CHANNEL_BLOCKS > 1) ? $clog2(MAX_CHANNEL_BLOCKS) : 1;
   localparam int CBL_W  = CB_W + 1;
   localparam int NIB_W  = im2col_agu_pkg::NIBBLE_W;
   localparam int KL_W   = NIB_W + 1;
   localparam int MV_W   = im2col_agu_pkg::MOVE_W;
   localparam int ROW_W  = SIDE_W + NIB_W + 1;
   localparam int TW     = CB_W + LIM_W + 1;
   localparam int PIX_W  = TW + LIM_W + 1;
   localparam int SRC_W  = im2col_agu_pkg::SRC_OFFSET_W;
   localparam int DST_W  = im2col_agu_pkg::DEST_OFFSET_W;
   localparam int LG     = im2col_agu_pkg::LANES_LOG2;

   function automatic logic [LIM_W-1:0] clamp_side(
      input logic [im2col_agu_pkg::SIZE_REG_W-1:0] v);
      logic [LIM_W-1:0] r;
      if (v == '0) begin
         r = LIM_W'(1);
      end else if (32'(v) > 32'(MAX_SIDE)) begin
         r = LIM_W'(MAX_SIDE);
      end else begin
         r = LIM_W'(v);
      end
      return r;
   endfunction

   function automatic logic [CBL_W-1:0] clamp_cb(
      input logic [im2col_agu_pkg::CB_REG_W-1:0] v);
      logic [CBL_W-1:0] r;
      if (v == '0) begin
         r = CBL_W'(1);
      end else if (32'(v) > 32'(MAX_CHANNEL_BLOCKS)) begin
         r = CBL_W'(MAX_CHANNEL_BLOCKS);
      end else begin
         r = CBL_W'(v);
      end
      return r;
   endfunction

   // Geometry decoded from the registers
   logic [LIM_W-1:0] sh_lim, sw_lim, oh_lim, ow_lim;
   logic [CBL_W-1:0] cb_lim;
   logic [NIB_W-1:0] kh, kw, sth, stw, dh, dw, ph, pw;

   assign sh_lim = clamp_side(cfg.src_height);
   assign sw_lim = clamp_side(cfg.src_width);
   assign oh_lim = clamp_side(cfg.out_height);
   assign ow_lim = clamp_side(cfg.out_width);
   assign cb_lim = clamp_cb(cfg.channel_blocks);
   assign kh  = im2col_agu_pkg::nz4(cfg.window_geometry[0*NIB_W +: NIB_W]);
   assign kw  = im2col_agu_pkg::nz4(cfg.window_geometry[1*NIB_W +: NIB_W]);
   assign sth = im2col_agu_pkg::nz4(cfg.window_geometry[2*NIB_W +: NIB_W]);
   assign stw = im2col_agu_pkg::nz4(cfg.window_geometry[3*NIB_W +: NIB_W]);
   assign dh  = im2col_agu_pkg::nz4(cfg.window_geometry[4*NIB_W +: NIB_W]);
   assign dw  = im2col_agu_pkg::nz4(cfg.window_geometry[5*NIB_W +: NIB_W]);
   assign ph  = cfg.window_geometry[6*NIB_W +: NIB_W];
   assign pw  = cfg.window_geometry[7*NIB_W +: NIB_W];

   // Handshake chain
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic rdy1, rdy2, rdy3, rdy_o, accept;

   assign rdy_o    = !out_v_ff || out_ready;
   assign rdy3     = !s3_v_ff || rdy_o;
   assign rdy2     = !s2_v_ff || rdy3;
   assign rdy1     = !s1_v_ff || rdy2;
   assign in_ready = rdy1;
   assign accept   = in_valid && rdy1;

   // Position counters
   logic [CB_W-1:0]   cb_ff, cb_in, cur_cb;
   logic [NIB_W-1:0]  kr_ff, kr_in, cur_kr, kc_ff, kc_in, cur_kc;
   logic [SIDE_W-1:0] or_ff, or_in, cur_or, oc_ff, oc_in, cur_oc;
   logic [MV_W-1:0]   mv_ff, mv_in, cur_mv;
   logic              cb_wrap, kr_wrap, kc_wrap, or_wrap, oc_wrap, cur_last;

   always_comb begin
      cur_cb = in_restart ? '0 : cb_ff;
      cur_kr = in_restart ? '0 : kr_ff;
      cur_kc = in_restart ? '0 : kc_ff;
      cur_or = in_restart ? '0 : or_ff;
      cur_oc = in_restart ? '0 : oc_ff;
      cur_mv = in_restart ? '0 : mv_ff;

      cb_wrap = (CBL_W'(cur_cb) + CBL_W'(1)) >= cb_lim;
      kr_wrap = (KL_W'(cur_kr) + KL_W'(1)) >= KL_W'(kh);
      kc_wrap = (KL_W'(cur_kc) + KL_W'(1)) >= KL_W'(kw);
      or_wrap = (LIM_W'(cur_or) + LIM_W'(1)) >= oh_lim;
      oc_wrap = (LIM_W'(cur_oc) + LIM_W'(1)) >= ow_lim;
      cur_last = cb_wrap && kr_wrap && kc_wrap && or_wrap && oc_wrap;

      cb_in = cur_cb;
      kr_in = cur_kr;
      kc_in = cur_kc;
      or_in = cur_or;
      oc_in = cur_oc;
      mv_in = cur_mv + MV_W'(1);
      if (cur_last) begin
         cb_in = '0;
         kr_in = '0;
         kc_in = '0;
         or_in = '0;
         oc_in = '0;
         mv_in = '0;
      end else begin
         oc_in = oc_wrap ? '0 : cur_oc + SIDE_W'(1);
         if (oc_wrap) begin
            or_in = or_wrap ? '0 : cur_or + SIDE_W'(1);
            if (or_wrap) begin
               kc_in = kc_wrap ? '0 : cur_kc + NIB_W'(1);
               if (kc_wrap) begin
                  kr_in = kr_wrap ? '0 : cur_kr + NIB_W'(1);
                  if (kr_wrap) begin
                     cb_in = cb_wrap ? '0 : cur_cb + CB_W'(1);
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cb_ff <= '0;
         kr_ff <= '0;
         kc_ff <= '0;
         or_ff <= '0;
         oc_ff <= '0;
         mv_ff <= '0;
      end else if (accept) begin
         cb_ff <= cb_in;
         kr_ff <= kr_in;
         kc_ff <= kc_in;
         or_ff <= or_in;
         oc_ff <= oc_in;
         mv_ff <= mv_in;
      end
   end

   // Stage payloads
   logic [CB_W-1:0]   s1_cb_ff, s2_cb_ff;
   logic [NIB_W-1:0]  s1_kr_ff, s1_kc_ff;
   logic [SIDE_W-1:0] s1_or_ff, s1_oc_ff, s2_ih_ff, s2_iw_ff, s3_iw_ff;
   logic [MV_W-1:0]   s1_mv_ff, s2_mv_ff, s3_mv_ff;
   logic              s1_last_ff, s2_last_ff, s3_last_ff;
   logic              s2_zero_ff, s3_zero_ff;
   logic [TW-1:0]     s3_t_ff;
   logic [SRC_W-1:0]  src_ff;
   logic [DST_W-1:0]  dest_ff;
   logic              zero_ff, last_ff;

   // Stage 1: input row and column, padding test
   logic [ROW_W-1:0]  row_sum, col_sum;
   logic              row_out, col_out;
   logic [SIDE_W-1:0] ih_in, iw_in;

   always_comb begin
      row_sum = ROW_W'(s1_or_ff) * ROW_W'(sth) + ROW_W'(s1_kr_ff) * ROW_W'(dh);
      col_sum = ROW_W'(s1_oc_ff) * ROW_W'(stw) + ROW_W'(s1_kc_ff) * ROW_W'(dw);
      row_out = (row_sum < ROW_W'(ph)) || ((row_sum - ROW_W'(ph)) >= ROW_W'(sh_lim));
      col_out = (col_sum < ROW_W'(pw)) || ((col_sum - ROW_W'(pw)) >= ROW_W'(sw_lim));
      ih_in   = SIDE_W'(row_sum - ROW_W'(ph));
      iw_in   = SIDE_W'(col_sum - ROW_W'(pw));
   end

   // Stage 2: row index within the channel block plane
   logic [TW-1:0] t_in;
   assign t_in = TW'(s2_cb_ff) * TW'(sh_lim) + TW'(s2_ih_ff);

   // Stage 3: pixel index, scaled to elements
   logic [PIX_W-1:0] pix;
   logic [SRC_W-1:0] src_in;
   logic [DST_W-1:0] dest_in;
   assign pix     = PIX_W'(s3_t_ff) * PIX_W'(sw_lim) + PIX_W'(s3_iw_ff);
   assign src_in  = s3_zero_ff ? '0 : SRC_W'({pix, {LG{1'b0}}});
   assign dest_in = DST_W'({s3_mv_ff, {LG{1'b0}}});

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
         s3_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_v_ff <= in_valid;
         end
         if (rdy2) begin
            s2_v_ff <= s1_v_ff;
         end
         if (rdy3) begin
            s3_v_ff <= s2_v_ff;
         end
         if (rdy_o) begin
            out_v_ff <= s3_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cb_ff   <= cur_cb;
         s1_kr_ff   <= cur_kr;
         s1_kc_ff   <= cur_kc;
         s1_or_ff   <= cur_or;
         s1_oc_ff   <= cur_oc;
         s1_mv_ff   <= cur_mv;
         s1_last_ff <= cur_last;
      end
      if (rdy2 && s1_v_ff) begin
         s2_cb_ff   <= s1_cb_ff;
         s2_ih_ff   <= ih_in;
         s2_iw_ff   <= iw_in;
         s2_zero_ff <= row_out || col_out;
         s2_mv_ff   <= s1_mv_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (rdy3 && s2_v_ff) begin
         s3_t_ff    <= t_in;
         s3_iw_ff   <= s2_iw_ff;
         s3_zero_ff <= s2_zero_ff;
         s3_mv_ff   <= s2_mv_ff;
         s3_last_ff <= s2_last_ff;
      end
      if (rdy_o && s3_v_ff) begin
         src_ff  <= src_in;
         dest_ff <= dest_in;
         zero_ff <= s3_zero_ff;
         last_ff <= s3_last_ff;
      end
   end

   assign out_valid         = out_v_ff;
   assign out_source_offset = src_ff;
   assign out_dest_offset   = dest_ff;
   assign out_zero_fill     = zero_ff;
   assign out_last_move     = last_ff;

endmodule

FILE: rtl/im2col_gather_address_generator_unit.sv
// im2col gather address generator for an image stored in blocks of eight
// channels. Each item on req_chan asks for one move of an eight-lane vector
// (restart=1 begins at the first move, restart=0 takes the next one) and
// yields exactly one item on rsp_chan: the source element offset (0 when the
// position lies in the padding and zero_fill is set), the destination offset
// in the column buffer, and last_move on the final move, after which the
// enumeration wraps to its start. Order is channel block, kernel row, kernel
// column, then output pixel in row-major order. The block takes one item
// every clock unless rsp_chan stalls; a result passes through four registers
// after its item is accepted: the counter snapshot, the padding test, and
// the two address multiplies, each of which has a stage of its own. Stalls on
// rsp_chan squeeze out empty stages first, so up to four items sit in flight.
// Program the registers over the APB port only while no item is in flight.
module im2col_gather_address_generator_unit #(
   parameter int MAX_SIDE           = im2col_agu_pkg::MAX_SIDE_DEF,
   parameter int MAX_CHANNEL_BLOCKS = im2col_agu_pkg::MAX_CHANNEL_BLOCKS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   im2col_agu_req_if.sink                         req_chan,
   im2col_agu_rsp_if.source                       rsp_chan,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [im2col_agu_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [im2col_agu_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [im2col_agu_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                   pready
);

   // Live configuration; the user must keep it stable while items are in flight, the block does not enforce it
   im2col_agu_pkg::cfg_type cfg;

   im2col_agu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Counters advance at acceptance; the address math follows in stages
   im2col_agu_core #(
      .MAX_SIDE           (MAX_SIDE),
      .MAX_CHANNEL_BLOCKS (MAX_CHANNEL_BLOCKS)
   ) u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .in_valid          (req_chan.valid),
      .in_ready          (req_chan.ready),
      .in_restart        (req_chan.restart),
      .out_valid         (rsp_chan.valid),
      .out_ready         (rsp_chan.ready),
      .out_source_offset (rsp_chan.source_offset),
      .out_dest_offset   (rsp_chan.dest_offset),
      .out_zero_fill     (rsp_chan.zero_fill),
      .out_last_move     (rsp_chan.last_move)
   );

`ifndef NO_ASSERTIONS
   // A padded position never carries a source address
   a_zero_no_src: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.zero_fill |-> rsp_chan.source_offset == '0)
      else $error("zero-filled item carries a nonzero source offset");

   // With nothing waiting at the output, the stage chain must take an item
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_chan.valid |-> req_chan.ready)
      else $error("input stalled while the output is empty");

   // Reset flushes every stage
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result valid right after reset");
`endif

endmodule
